// File: rtl/ccpg_pkg.sv
// ---------------------------------------------------------------------------
// ccpg_pkg
// Shared types and constants of the concentric circle point generator.
// ---------------------------------------------------------------------------
package ccpg_pkg;

    // input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // midpoint decision constants
    localparam int DEC_INIT = 3;
    localparam int DEC_DIAG = 10;
    localparam int DEC_AXIS = 6;

    // index of the eighth symmetric point
    localparam logic [2:0] LAST_IDX = 3'd7;

    // handoff of one job from the stepper to the emitter
    typedef struct packed {
        logic valid;  // job waiting in the job register
        logic fin;    // job is a done marker, not a point set
    } job_ctl_t;

endpackage

// File: rtl/ccpg_state.sv
// ---------------------------------------------------------------------------
// ccpg_state
// Circle state registers, one midpoint step per transaction, job register.
// ---------------------------------------------------------------------------
module ccpg_state
    import ccpg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_fire,
    input  logic                    cmd,
    input  logic [COORD_BITS-1:0]   canvas_width,
    input  logic [COORD_BITS-1:0]   canvas_height,
    input  logic                    job_take,
    output logic                    in_ready,
    output job_ctl_t                job_ctl,
    output logic [COORD_BITS-2:0]   job_cx,
    output logic [COORD_BITS-2:0]   job_cy,
    output logic [COORD_BITS-2:0]   job_px,
    output logic [COORD_BITS-2:0]   job_py
);

    localparam int HW = COORD_BITS - 1;
    localparam int DW = COORD_BITS + 4;

    logic [HW-1:0]        center_x_reg, center_x_next;
    logic [HW-1:0]        center_y_reg, center_y_next;
    logic [HW-1:0]        radius_reg, radius_next;
    logic [HW-1:0]        pos_x_reg, pos_x_next;
    logic [HW-1:0]        pos_y_reg, pos_y_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic                 fin_next;

    logic                 job_valid_reg;
    logic                 job_fin_reg;
    logic [HW-1:0]        job_cx_reg, job_cy_reg, job_px_reg, job_py_reg;

    logic [COORD_BITS-1:0] small_dim;
    logic [HW-1:0]         start_r;
    logic [HW-1:0]         dec_r;
    logic [HW-1:0]         step_x;
    logic [HW-1:0]         step_y;
    logic signed [DW-1:0]  diff_xy;

    always_comb
    begin
        small_dim = (canvas_width > canvas_height) ? canvas_height : canvas_width;
        start_r   = small_dim[COORD_BITS-1:1];
        dec_r     = radius_reg - HW'(1);
        step_x    = pos_x_reg + HW'(1);
        step_y    = pos_y_reg - HW'(1);
        diff_xy   = $signed(DW'(step_x)) - $signed(DW'(step_y));

        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        radius_next   = radius_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        decision_next = decision_reg;
        fin_next      = 1'b0;

        if (cmd == CMD_START)
        begin
            center_x_next = canvas_width[COORD_BITS-1:1];
            center_y_next = canvas_height[COORD_BITS-1:1];
            radius_next   = start_r;
            pos_x_next    = '0;
            if (start_r == '0)
            begin
                pos_y_next    = '0;
                decision_next = '0;
                fin_next      = 1'b1;
            end
            else
            begin
                pos_y_next    = start_r;
                decision_next = DW'(DEC_INIT) - $signed(DW'({start_r, 1'b0}));
            end
        end
        else if (radius_reg == '0)
        begin
            fin_next = 1'b1;
        end
        else if (pos_y_reg >= pos_x_reg)
        begin
            pos_x_next = step_x;
            if (decision_reg > 0)
            begin
                pos_y_next    = step_y;
                decision_next = decision_reg + (diff_xy <<< 2) + DW'(DEC_DIAG);
            end
            else
            begin
                decision_next = decision_reg + $signed(DW'(step_x) << 2) + DW'(DEC_AXIS);
            end
        end
        else
        begin
            // octant finished: shrink, restart at (0,r) or finish
            radius_next = dec_r;
            pos_x_next  = '0;
            if (dec_r == '0)
            begin
                pos_y_next    = '0;
                decision_next = '0;
                fin_next      = 1'b1;
            end
            else
            begin
                pos_y_next    = dec_r;
                decision_next = DW'(DEC_INIT) - $signed(DW'({dec_r, 1'b0}));
            end
        end
    end

    assign in_ready = !job_valid_reg || job_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            decision_reg  <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                center_x_reg  <= center_x_next;
                center_y_reg  <= center_y_next;
                radius_reg    <= radius_next;
                pos_x_reg     <= pos_x_next;
                pos_y_reg     <= pos_y_next;
                decision_reg  <= decision_next;
                job_valid_reg <= 1'b1;
            end
            else if (job_take)
            begin
                job_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            job_fin_reg <= fin_next;
            job_cx_reg  <= center_x_next;
            job_cy_reg  <= center_y_next;
            job_px_reg  <= pos_x_next;
            job_py_reg  <= pos_y_next;
        end
    end

    assign job_ctl.valid = job_valid_reg;
    assign job_ctl.fin   = job_fin_reg;
    assign job_cx        = job_cx_reg;
    assign job_cy        = job_cy_reg;
    assign job_px        = job_px_reg;
    assign job_py        = job_py_reg;

endmodule

// File: rtl/ccpg_emit.sv
// ---------------------------------------------------------------------------
// ccpg_emit
// Expands one job into eight symmetric points or a done marker, output register.
// ---------------------------------------------------------------------------
module ccpg_emit
    import ccpg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  job_ctl_t                job_ctl,
    input  logic [COORD_BITS-2:0]   job_cx,
    input  logic [COORD_BITS-2:0]   job_cy,
    input  logic [COORD_BITS-2:0]   job_px,
    input  logic [COORD_BITS-2:0]   job_py,
    output logic                    job_take,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [COORD_BITS-1:0]   point_x,
    output logic [COORD_BITS-1:0]   point_y,
    output logic                    point_valid,
    output logic                    done_res,
    output logic                    last
);

    localparam int HW = COORD_BITS - 1;

    logic                  act_reg, act_next;
    logic                  fin_reg;
    logic [2:0]            idx_reg, idx_next;
    logic [HW-1:0]         cx_reg, cy_reg, px_reg, py_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] point_x_reg, point_x_next;
    logic [COORD_BITS-1:0] point_y_reg, point_y_next;
    logic                  point_valid_reg, point_valid_next;
    logic                  done_reg, done_next;
    logic                  last_reg, last_next;

    logic                  out_free;
    logic                  finishing;
    logic                  load;
    logic [COORD_BITS-1:0] off_a, off_b;
    logic [COORD_BITS-1:0] base_x, base_y;
    logic [COORD_BITS-1:0] sym_x, sym_y;

    assign out_free  = !out_valid_reg || out_ready;
    assign finishing = out_free && act_reg && (fin_reg || idx_reg == LAST_IDX);
    assign load      = job_ctl.valid && (!act_reg || finishing);
    assign job_take  = load;

    always_comb
    begin
        // upper four points swap the roles of x and y
        off_a  = idx_reg[2] ? COORD_BITS'(py_reg) : COORD_BITS'(px_reg);
        off_b  = idx_reg[2] ? COORD_BITS'(px_reg) : COORD_BITS'(py_reg);
        base_x = COORD_BITS'(cx_reg);
        base_y = COORD_BITS'(cy_reg);
        sym_x  = idx_reg[0] ? (base_x - off_a) : (base_x + off_a);
        sym_y  = idx_reg[1] ? (base_y - off_b) : (base_y + off_b);

        act_next         = act_reg;
        idx_next         = idx_reg;
        out_valid_next   = out_valid_reg;
        point_x_next     = point_x_reg;
        point_y_next     = point_y_reg;
        point_valid_next = point_valid_reg;
        done_next        = done_reg;
        last_next        = last_reg;

        if (out_free)
        begin
            out_valid_next = 1'b0;
            if (act_reg)
            begin
                out_valid_next = 1'b1;
                if (fin_reg)
                begin
                    point_x_next     = '0;
                    point_y_next     = '0;
                    point_valid_next = 1'b0;
                    done_next        = 1'b1;
                    last_next        = 1'b1;
                    act_next         = 1'b0;
                end
                else
                begin
                    point_x_next     = sym_x;
                    point_y_next     = sym_y;
                    point_valid_next = 1'b1;
                    done_next        = 1'b0;
                    last_next        = (idx_reg == LAST_IDX);
                    idx_next         = idx_reg + 3'd1;
                    if (idx_reg == LAST_IDX)
                    begin
                        act_next = 1'b0;
                    end
                end
            end
        end

        if (load)
        begin
            act_next = 1'b1;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_reg       <= act_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fin_reg <= job_ctl.fin;
            cx_reg  <= job_cx;
            cy_reg  <= job_cy;
            px_reg  <= job_px;
            py_reg  <= job_py;
        end
        point_x_reg     <= point_x_next;
        point_y_reg     <= point_y_next;
        point_valid_reg <= point_valid_next;
        done_reg        <= done_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign point_x     = point_x_reg;
    assign point_y     = point_y_reg;
    assign point_valid = point_valid_reg;
    assign done_res    = done_reg;
    assign last        = last_reg;

endmodule

// File: rtl/concentric_circle_point_generator.sv
// ---------------------------------------------------------------------------
// concentric_circle_point_generator
// Midpoint circle walker: eight symmetric points or a done marker per item.
// ---------------------------------------------------------------------------
//  channel | dir | payload                                   | per transaction
//  s_      | in  | tdata: canvas_width, canvas_height        | one start or step
//          |     | tuser: cmd                                |
//  m_      | out | tdata: point_x, point_y                   | one point or done
//          |     | tuser: point_valid, done_res; tlast: last |
//
//  A point item yields eight output transactions on consecutive cycles while
//  m_tready is high, a done item yields one; the single output register
//  sets this rate. The step itself finishes in the accept cycle; one job
//  register lets the next input be taken while the previous job is still
//  being emitted. Stalls on m_tready hold the output register and back up
//  into s_tready. Reset clears the circle state to zero; the first step
//  without a start yields a done result.
// ---------------------------------------------------------------------------
module concentric_circle_point_generator
    import ccpg_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // canvas_width, canvas_height (lowest first), zero padded
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // cmd
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // point_x, point_y (lowest first), zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]      m_tdata,
    // point_valid, done_res (lowest first)
    output logic [1:0]                             m_tuser,
    output logic                                   m_tlast
);

    localparam int DATA_W = ((2*COORD_BITS+7)/8)*8;

    logic                  in_fire;
    logic                  job_take;
    job_ctl_t              job_ctl;
    logic [COORD_BITS-2:0] job_cx, job_cy, job_px, job_py;
    logic [COORD_BITS-1:0] point_x, point_y;
    logic                  point_valid, done_res;

    assign in_fire = s_tvalid && s_tready;

    ccpg_state #(
        .COORD_BITS    (COORD_BITS)
    ) u_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .cmd           (s_tuser),
        .canvas_width  (s_tdata[COORD_BITS-1:0]),
        .canvas_height (s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .job_take      (job_take),
        .in_ready      (s_tready),
        .job_ctl       (job_ctl),
        .job_cx        (job_cx),
        .job_cy        (job_cy),
        .job_px        (job_px),
        .job_py        (job_py)
    );

    ccpg_emit #(
        .COORD_BITS    (COORD_BITS)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_ctl       (job_ctl),
        .job_cx        (job_cx),
        .job_cy        (job_cy),
        .job_px        (job_px),
        .job_py        (job_py),
        .job_take      (job_take),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_valid   (point_valid),
        .done_res      (done_res),
        .last          (m_tlast)
    );

    assign m_tdata = DATA_W'({point_y, point_x});
    assign m_tuser = {done_res, point_valid};

endmodule

// File: sim/concentric_circle_point_generator_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// concentric_circle_point_generator_test
// Drives start and step transactions into the circle point generator and
// checks every emitted point or done marker against a midpoint predictor.
// ---------------------------------------------------------------------------
module concentric_circle_point_generator_test;
    import ccpg_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int DATA_W      = ((2*COORD_BITS+7)/8)*8;
    localparam int ITEM_TARGET = 410;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 32;
    localparam int REPORT_MAX  = 10;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [COORD_BITS-2:0] half_t;

    typedef struct {
        coord_t px;
        coord_t py;
        logic   valid;
        logic   done;
        logic   last;
    } point_t;

    class point_scoreboard;
        half_t  center_x;
        half_t  center_y;
        half_t  radius;
        half_t  pos_x;
        half_t  pos_y;
        int     decision;
        point_t expected_points[$];
        int     start_count;
        int     step_count;
        int     point_count;
        int     done_count;
        int     mismatches;

        function new();
            center_x    = '0;
            center_y    = '0;
            radius      = '0;
            pos_x       = '0;
            pos_y       = '0;
            decision    = 0;
            start_count = 0;
            step_count  = 0;
            point_count = 0;
            done_count  = 0;
            mismatches  = 0;
        endfunction

        function void push_point(coord_t px, coord_t py, logic lastf);
            point_t p;
            p.px    = px;
            p.py    = py;
            p.valid = 1'b1;
            p.done  = 1'b0;
            p.last  = lastf;
            expected_points.push_back(p);
        endfunction

        function void push_done();
            point_t p;
            p.px    = '0;
            p.py    = '0;
            p.valid = 1'b0;
            p.done  = 1'b1;
            p.last  = 1'b1;
            expected_points.push_back(p);
        endfunction

        // eight-way symmetric points of the current octant position
        function void push_octants();
            coord_t cx;
            coord_t cy;
            coord_t x;
            coord_t y;
            cx = {1'b0, center_x};
            cy = {1'b0, center_y};
            x  = {1'b0, pos_x};
            y  = {1'b0, pos_y};
            push_point(cx + x, cy + y, 1'b0);
            push_point(cx - x, cy + y, 1'b0);
            push_point(cx + x, cy - y, 1'b0);
            push_point(cx - x, cy - y, 1'b0);
            push_point(cx + y, cy + x, 1'b0);
            push_point(cx - y, cy + x, 1'b0);
            push_point(cx + y, cy - x, 1'b0);
            push_point(cx - y, cy - x, 1'b1);
        endfunction

        function void clear_walk();
            pos_x    = '0;
            pos_y    = '0;
            decision = 0;
        endfunction

        function void open_circle();
            pos_x    = '0;
            pos_y    = radius;
            decision = DEC_INIT - 2 * int'(radius);
        endfunction

        function void note_request(logic cmd, coord_t w, coord_t h);
            coord_t smaller;
            if (cmd == CMD_START) begin
                start_count++;
                smaller  = (w > h) ? h : w;
                center_x = w[COORD_BITS-1:1];
                center_y = h[COORD_BITS-1:1];
                radius   = smaller[COORD_BITS-1:1];
                if (radius == '0) begin
                    clear_walk();
                    push_done();
                end
                else begin
                    open_circle();
                    push_octants();
                end
                return;
            end
            step_count++;
            if (radius == '0) begin
                push_done();
            end
            else if (pos_y >= pos_x) begin
                pos_x = pos_x + 1'b1;
                if (decision > 0) begin
                    pos_y    = pos_y - 1'b1;
                    decision = decision + 4 * (int'(pos_x) - int'(pos_y)) + DEC_DIAG;
                end
                else begin
                    decision = decision + 4 * int'(pos_x) + DEC_AXIS;
                end
                push_octants();
            end
            else begin
                // octant finished: shrink and restart, or finish the pattern
                radius = radius - 1'b1;
                if (radius == '0) begin
                    clear_walk();
                    push_done();
                end
                else begin
                    open_circle();
                    push_octants();
                end
            end
        endfunction

        function void check_point(logic [DATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
            point_t exp_p;
            coord_t got_x;
            coord_t got_y;
            got_x = tdata[COORD_BITS-1:0];
            got_y = tdata[2*COORD_BITS-1:COORD_BITS];
            if (expected_points.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: unexpected transaction x=%0d y=%0d",
                             got_x, got_y,
                             " valid=%0b done=%0b last=%0b",
                             tuser[0], tuser[1], tlast);
                return;
            end
            exp_p = expected_points.pop_front();
            if (tuser[1])
                done_count++;
            else
                point_count++;
            if (got_x !== exp_p.px || got_y !== exp_p.py || tuser[0] !== exp_p.valid ||
                tuser[1] !== exp_p.done || tlast !== exp_p.last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("ERROR: expected x=%0d y=%0d valid=%0b done=%0b last=%0b,",
                             exp_p.px, exp_p.py, exp_p.valid, exp_p.done, exp_p.last,
                             " got x=%0d y=%0d valid=%0b done=%0b last=%0b",
                             got_x, got_y, tuser[0], tuser[1], tlast);
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;
    logic              m_tlast;

    point_scoreboard scoreboard = new();
    bit              steady;
    int              sent_count;
    int              cycle_count;

    concentric_circle_point_generator #(
        .COORD_BITS (COORD_BITS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
        end
    end

    // receiver side: stall at random except during the steady stretch
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= steady ? 1'b1 : ($urandom_range(99) >= 37);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            scoreboard.check_point(m_tdata, m_tuser, m_tlast);
    end

    task automatic send_item(input logic cmd, input coord_t w, input coord_t h);
        while (!steady && $urandom_range(99) < 37)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= DATA_W'({h, w});
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        scoreboard.note_request(cmd, w, h);
        sent_count++;
        @(negedge clk);
    endtask

    // hold the sender until every expected result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic step_burst(input int n);
        for (int i = 0; i < n && sent_count < ITEM_TARGET; i++)
            send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom));
    endtask

    initial
    begin
        int     pick;
        coord_t w;
        coord_t h;
        bit     drained_mid;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = CMD_START;
        steady      = 1'b0;
        sent_count  = 0;
        drained_mid = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: step before any start, degenerate canvases, extremes
        send_item(CMD_STEP, 12'h000, 12'h000);
        send_item(CMD_START, 12'h000, 12'h000);
        send_item(CMD_START, 12'h001, 12'hFFF);
        send_item(CMD_STEP, 12'hFFF, 12'hFFF);
        // radius one: the start and a step give points, then the done marker, then done again
        send_item(CMD_START, 12'hFFF, 12'h002);
        step_burst(3);
        send_item(CMD_START, 12'hFFF, 12'hFFF);
        step_burst(2);
        // radius two walked to the end, through a shrink and a restart
        send_item(CMD_START, 12'h004, 12'h005);
        step_burst(8);
        send_item(CMD_START, 12'h800, 12'hBB8);
        drain_results();

        while (sent_count < ITEM_TARGET)
        begin
            steady = (sent_count >= 150 && sent_count < 230);
            if (!drained_mid && sent_count >= 280)
            begin
                drain_results();
                drained_mid = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 12)
            begin
                send_item(1'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom));
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 70)
                begin
                    w = coord_t'($urandom_range(1, 14));
                    h = coord_t'($urandom_range(1, 14));
                end
                else if (pick < 85)
                begin
                    w = coord_t'($urandom);
                    h = coord_t'($urandom);
                end
                else
                begin
                    w = 12'hFFF;
                    h = coord_t'($urandom_range(0, 12));
                    if ($urandom_range(1))
                    begin
                        w = h;
                        h = 12'hFFF;
                    end
                end
                send_item(CMD_START, w, h);
                step_burst($urandom_range(0, 45));
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d starts and %0d steps; checked %0d points and %0d done markers.",
                 scoreboard.start_count, scoreboard.step_count,
                 scoreboard.point_count, scoreboard.done_count);
        if (scoreboard.mismatches > REPORT_MAX)
            $display("%0d mismatches in total", scoreboard.mismatches);
        if (scoreboard.mismatches == 0 && scoreboard.pending() == 0)
            $display("** concentric_circle_point_generator: PASSED **");
        else
            $display("** concentric_circle_point_generator: FAILED **");
        $finish;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                 cycle_count, scoreboard.pending());
        $display("** concentric_circle_point_generator: FAILED **");
        $finish;
    end

endmodule
